/* sv/length_prefix_deframer_unit_macros.svh */
`ifndef LENGTH_PREFIX_DEFRAMER_UNIT_MACROS_SVH
`define LENGTH_PREFIX_DEFRAMER_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define LPD_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define LPD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/lpd_pkg.sv */
package lpd_pkg;

    localparam int LENGTH_BYTES_DEFAULT = 4;
    localparam logic [31:0] MAX_FRAME_LEN_RESET = 32'd10485760;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_ERROR   = 2'd2
    } phase_t;

endpackage

/* sv/length_prefix_deframer_unit.sv */
// Length-prefixed stream deframer.
// The slave channel takes one received byte per transfer in s_axis_tdata.
// Each frame opens with a LENGTH_BYTES big-endian length header followed by
// that many payload bytes. Payload bytes leave on the master channel as they
// arrive, with m_axis_tlast on the last byte of each frame. A zero length
// header gives one transfer with empty_frame and tlast set and zero data. A
// length above max_frame_len (written through cfg_wr_en / cfg_wr_data and
// compared when a header completes) gives one transfer with length_error
// set; after that every input byte is taken and dropped until reset.
// The output is registered: a byte taken at one edge is on the master channel
// right after that edge. Throughput is one byte per cycle while m_axis_tready
// holds, set by the single output register, refilled in the same cycle it is drained.
// When the receiver stalls with a result held, s_axis_tready drops until
// m_axis_tready returns; header bytes still wait behind the held result.
// Reset is asynchronous and active low: it returns to the header phase,
// empties the output register and sets max_frame_len to 10485760.
`include "length_prefix_deframer_unit_macros.svh"

module length_prefix_deframer_unit
    import lpd_pkg::*;
#(
    parameter int LENGTH_BYTES = LENGTH_BYTES_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,   // max_frame_len
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,  // in_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,  // payload_byte
    output logic        m_axis_tlast,  // last_of_frame
    output logic [1:0]  m_axis_tuser   // empty_frame, length_error
);

    localparam int CW = $clog2(LENGTH_BYTES + 1);

    phase_t      phase_reg, phase_next;
    logic [CW-1:0] count_reg, count_next;
    logic [31:0] shift_reg, shift_next;
    logic [31:0] left_reg, left_next;
    logic        ovf_reg, ovf_next;
    logic [31:0] max_len_reg;

    logic        out_valid_reg;
    logic [7:0]  out_byte_reg;
    logic        out_last_reg;
    logic        out_empty_reg;
    logic        out_err_reg;

    logic        accept;
    logic        out_load;
    logic [7:0]  res_byte;
    logic        res_last;
    logic        res_empty;
    logic        res_err;

    logic [CW-1:0] hdr_count;
    logic [31:0]   hdr_shift;
    logic          hdr_ovf;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign hdr_count = count_reg + CW'(1);
    assign hdr_shift = {shift_reg[23:0], s_axis_tdata};
    assign hdr_ovf   = ovf_reg || (shift_reg[31:24] != 8'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            count_reg <= '0;
            shift_reg <= '0;
            left_reg  <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            shift_reg <= shift_next;
            left_reg  <= left_next;
            ovf_reg   <= ovf_next;
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        shift_next = shift_reg;
        left_next  = left_reg;
        ovf_next   = ovf_reg;
        out_load   = 1'b0;
        res_byte   = 8'd0;
        res_last   = 1'b0;
        res_empty  = 1'b0;
        res_err    = 1'b0;
        if (accept)
        begin
            unique case (phase_reg)
                PH_PAYLOAD:
                begin
                    out_load = 1'b1;
                    res_byte = s_axis_tdata;
                    res_last = (left_reg <= 32'd1);
                    if (left_reg <= 32'd1)
                    begin
                        left_next  = '0;
                        phase_next = PH_HEADER;
                    end
                    else
                    begin
                        left_next = left_reg - 32'd1;
                    end
                end
                PH_HEADER:
                begin
                    count_next = hdr_count;
                    shift_next = hdr_shift;
                    ovf_next   = hdr_ovf;
                    if (hdr_count == CW'(LENGTH_BYTES))
                    begin
                        count_next = '0;
                        shift_next = '0;
                        ovf_next   = 1'b0;
                        if (hdr_ovf || (hdr_shift > max_len_reg))
                        begin
                            phase_next = PH_ERROR;
                            left_next  = '0;
                            out_load   = 1'b1;
                            res_err    = 1'b1;
                        end
                        else if (hdr_shift == 32'd0)
                        begin
                            out_load  = 1'b1;
                            res_last  = 1'b1;
                            res_empty = 1'b1;
                        end
                        else
                        begin
                            left_next  = hdr_shift;
                            phase_next = PH_PAYLOAD;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= MAX_FRAME_LEN_RESET;
        end
        else if (cfg_wr_en)
        begin
            max_len_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_byte_reg  <= res_byte;
            out_last_reg  <= res_last;
            out_empty_reg <= res_empty;
            out_err_reg   <= res_err;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_byte_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = {out_err_reg, out_empty_reg};

    `LPD_ASSERT_NEXT(a_error_silent, clk, rst_n,
        (phase_reg == PH_ERROR) && !out_valid_reg, !out_valid_reg,
        "result produced while discarding after a length error")
    `LPD_ASSERT_IMPLIES(a_payload_count, clk, rst_n,
        phase_reg == PH_PAYLOAD, left_reg != 32'd0,
        "payload phase with no bytes left")
    `LPD_ASSERT_IMPLIES(a_error_shape, clk, rst_n,
        out_valid_reg && out_err_reg,
        !out_last_reg && !out_empty_reg && (out_byte_reg == 8'd0),
        "length error result carries data or flags")
    `LPD_ASSERT_IMPLIES(a_empty_shape, clk, rst_n,
        out_valid_reg && out_empty_reg,
        out_last_reg && (out_byte_reg == 8'd0),
        "empty frame result not marked last or carries data")

endmodule

/* tb/deframer_checker.sv */
module deframer_checker
    import lpd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // in_byte
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [7:0]  m_axis_tdata,   // payload_byte
    input  logic        m_axis_tlast,   // last_of_frame
    input  logic [1:0]  m_axis_tuser,   // empty_frame, length_error
    output int          fails,
    output int          pending
);

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       empty;
        logic       err;
    } deframe_out_t;

    deframe_out_t due_q[$];
    phase_t       ph;
    logic [3:0]   hdr_count;
    logic [31:0]  len_acc;
    logic [31:0]  bytes_left;
    logic [31:0]  max_len;
    logic         len_wide;
    int           err_count = 0;
    int           due_count = 0;

    assign fails   = err_count;
    assign pending = due_count;

    task automatic predict_deframe(input logic [7:0] b);
        deframe_out_t r;
        logic [31:0]  len;
        logic         too_long;
        r = '0;
        case (ph)
            PH_PAYLOAD:
            begin
                r.data = b;
                r.last = (bytes_left <= 32'd1);
                due_q.push_back(r);
                if (bytes_left > 0)
                    bytes_left = bytes_left - 1;
                if (bytes_left == 0)
                    ph = PH_HEADER;
            end
            PH_HEADER:
            begin
                if (len_acc[31:24] != 0)
                    len_wide = 1'b1;
                len_acc   = {len_acc[23:0], b};
                hdr_count = hdr_count + 4'd1;
                if (hdr_count == LENGTH_BYTES_DEFAULT)
                begin
                    len       = len_acc;
                    too_long  = len_wide || (len > max_len);
                    hdr_count = '0;
                    len_acc   = '0;
                    len_wide  = 1'b0;
                    if (too_long)
                    begin
                        ph         = PH_ERROR;
                        bytes_left = '0;
                        r.err      = 1'b1;
                        due_q.push_back(r);
                    end
                    else if (len == 0)
                    begin
                        r.last  = 1'b1;
                        r.empty = 1'b1;
                        due_q.push_back(r);
                    end
                    else
                    begin
                        bytes_left = len;
                        ph         = PH_PAYLOAD;
                    end
                end
            end
            default:
                ;
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        deframe_out_t want;
        if (!rst_n)
        begin
            ph         = PH_HEADER;
            hdr_count  = '0;
            len_acc    = '0;
            bytes_left = '0;
            len_wide   = 1'b0;
            max_len    = MAX_FRAME_LEN_RESET;
            due_q.delete();
            due_count  = 0;
        end
        else
        begin
            if (cfg_wr_en)
                max_len = cfg_wr_data;
            if (s_axis_tvalid && s_axis_tready)
                predict_deframe(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (due_q.size() == 0)
                begin
                    $error("result transfer with none due: payload_byte %0h", m_axis_tdata);
                    err_count++;
                end
                else
                begin
                    want = due_q.pop_front();
                    if (m_axis_tdata !== want.data)
                    begin
                        $error("payload_byte: expected %0h, actual %0h",
                               want.data, m_axis_tdata);
                        err_count++;
                    end
                    if (m_axis_tlast !== want.last)
                    begin
                        $error("last_of_frame: expected %0b, actual %0b",
                               want.last, m_axis_tlast);
                        err_count++;
                    end
                    if (m_axis_tuser[0] !== want.empty)
                    begin
                        $error("empty_frame: expected %0b, actual %0b",
                               want.empty, m_axis_tuser[0]);
                        err_count++;
                    end
                    if (m_axis_tuser[1] !== want.err)
                    begin
                        $error("length_error: expected %0b, actual %0b",
                               want.err, m_axis_tuser[1]);
                        err_count++;
                    end
                end
            end
            due_count = due_q.size();
        end
    end

endmodule

/* tb/tb_length_prefix_deframer_unit.sv */
module tb_length_prefix_deframer_unit;
    import lpd_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_BYTES = 1750;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        cfg_wr_en     = 1'b0;
    logic [31:0] cfg_wr_data   = '0;
    logic        s_axis_tvalid = 1'b0;
    logic [7:0]  s_axis_tdata  = '0;
    logic        m_axis_tready = 1'b0;
    logic        s_axis_tready;
    logic        m_axis_tvalid;
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tlast;
    logic [1:0]  m_axis_tuser;
    int          fails;
    int          pending;
    int          cycles = 0;
    int          sent   = 0;
    logic        calm;

    always #10 clk = ~clk;

    // long stretches with no gaps on either side
    assign calm = (cycles % 3000) >= 2000;

    length_prefix_deframer_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    deframer_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .fails         (fails),
        .pending       (pending)
    );

    always @(posedge clk)
    begin
        cycles        <= cycles + 1;
        m_axis_tready <= calm || ($urandom_range(0, 99) >= 6);
        if (cycles == CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b);
        if (!calm && $urandom_range(0, 99) < 6)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do @(posedge clk); while (!s_axis_tready);
        sent++;
    endtask

    task automatic send_header(input logic [31:0] len);
        for (int i = 3; i >= 0; i--)
            send_byte(len[8*i +: 8]);
    endtask

    task automatic send_frame(input logic [31:0] len);
        send_header(len);
        repeat (len) send_byte(8'($urandom_range(0, 255)));
    endtask

    // all due results in, then a wait for the output register to empty
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (3) @(posedge clk);
    endtask

    task automatic set_max_len(input logic [31:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    function automatic int unsigned pick_len(input logic [31:0] max_len);
        int unsigned cap;
        cap = (max_len < 48) ? max_len : 48;
        case ($urandom_range(0, 9))
            0:       return cap;
            1:       return 0;
            default: return $urandom_range(0, (cap < 12) ? cap : 12);
        endcase
    endfunction

    initial
    begin
        logic [31:0] phase_max [6];
        int          quota;
        int          mark;
        logic [31:0] len;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset limit, empty frames, zero limit, length equal to limit
        send_header(1);
        send_byte(8'hFF);
        send_header(0);
        drain();
        set_max_len(0);
        send_header(0);
        drain();
        set_max_len(3);
        send_header(3);
        send_byte(8'h00);
        send_byte(8'h80);
        send_byte(8'h7F);

        phase_max = '{32'hFFFF_FFFF, 32'd0, 32'd1, 32'd16, MAX_FRAME_LEN_RESET, 32'd0};
        phase_max[5] = $urandom_range(2, 60);
        quota = RANDOM_BYTES / 6;
        foreach (phase_max[p])
        begin
            drain();
            set_max_len(phase_max[p]);
            mark = sent;
            while (sent - mark < quota)
                send_frame(pick_len(phase_max[p]));
        end

        // limit rewritten between header bytes
        drain();
        set_max_len(1);
        send_byte(8'h00);
        send_byte(8'h00);
        drain();
        set_max_len(16);
        send_byte(8'h00);
        send_byte(8'd9);
        repeat (9) send_byte(8'($urandom_range(0, 255)));

        // length one above the limit, then every byte is dropped
        drain();
        len = $urandom_range(0, 60);
        set_max_len(len);
        send_header(len + 1);
        repeat (16) send_byte(8'($urandom_range(0, 255)));
        drain();

        if (fails == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

/* length_prefix_deframer_unit.f */
+incdir+sv
sv/lpd_pkg.sv
sv/length_prefix_deframer_unit.sv
tb/deframer_checker.sv
tb/tb_length_prefix_deframer_unit.sv
